// ----- sv/drive_command_safety_gate_assert.svh -----
// Assertion macros shared by the drive command safety gate RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef DRIVE_COMMAND_SAFETY_GATE_ASSERT_SVH
`define DRIVE_COMMAND_SAFETY_GATE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DCSG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dcsg assertion failed");

// Next-cycle implication.
`define DCSG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dcsg assertion failed");

`endif

// ----- sv/dcsg_pkg.sv -----
// Shared types and constants for the drive command safety gate.
// No dependencies; imported by every module of the block.
`default_nettype none

package dcsg_pkg;

    // Request kinds carried on the input tuser.
    typedef enum logic [1:0] {
        CMD_AUTO    = 2'd0,
        CMD_EMG     = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_PUBLISH = 2'd3
    } t_cmd;

    // Where a published command came from.
    typedef enum logic [2:0] {
        KIND_EMG_LABEL     = 3'd0,
        KIND_EMG_DEFAULT   = 3'd1,
        KIND_WDOG_STOP     = 3'd2,
        KIND_AUTO_DISABLED = 3'd3,
        KIND_AUTO_LABEL    = 3'd4,
        KIND_AUTO_DEFAULT  = 3'd5
    } t_kind;

    // Configuration register indexes.
    localparam logic [2:0] REG_WATCHDOG    = 3'd0;
    localparam logic [2:0] REG_EMG_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_MAX_VX      = 3'd2;
    localparam logic [2:0] REG_MAX_VY      = 3'd3;
    localparam logic [2:0] REG_MAX_WZ      = 3'd4;
    localparam logic [2:0] REG_SLEW_VX     = 3'd5;
    localparam logic [2:0] REG_SLEW_VY     = 3'd6;
    localparam logic [2:0] REG_SLEW_WZ     = 3'd7;

    localparam logic [15:0] RST_WATCHDOG    = 16'd200;
    localparam logic [15:0] RST_EMG_TIMEOUT = 16'd300;
    localparam logic [14:0] RST_MAX_V       = 15'd2458;
    localparam logic [14:0] RST_MAX_WZ      = 15'd6554;
    localparam logic [15:0] RST_SLEW_V      = 16'd131;
    localparam logic [15:0] RST_SLEW_WZ     = 16'd262;

    localparam logic [16:0] AGE_MAX = 17'h1FFFF;
    localparam logic [15:0] PUB_MAX = 16'hFFFF;

    // Decision inputs from the command store to the output select.
    typedef struct packed {
        logic        emg_fresh;
        logic        auto_live;
        logic        auto_en;
        logic        auto_lbl;
        logic        emg_en;
        logic        emg_lbl;
        logic [15:0] dt;
    } t_status;

endpackage

`default_nettype wire

// ----- sv/dcsg_axis.sv -----
// One gate axis: clamp of both commands (emergency per EMG_CLAMP_EN), auto slew.
// Depends on dcsg_pkg.
`default_nettype none

module dcsg_axis
    import dcsg_pkg::*;
#(
    parameter int EMG_CLAMP_EN = 1
) (
    input  wire logic signed [15:0] i_emg_v,
    input  wire logic signed [15:0] i_auto_v,
    input  wire logic signed [15:0] i_prev_v,
    input  wire logic        [14:0] i_lim,
    input  wire logic        [15:0] i_rate,
    input  wire logic        [15:0] i_dt,
    output logic signed      [15:0] o_emg_v,
    output logic signed      [15:0] o_auto_v
);

    function automatic logic signed [15:0] f_clamp(logic signed [15:0] v, logic [14:0] l);
        logic signed [16:0] vs;
        logic signed [16:0] ls;
        logic signed [16:0] nl;
        vs = {v[15], v};
        ls = {2'b00, l};
        nl = -ls;
        if (vs > ls) begin
            return ls[15:0];
        end else if (vs < nl) begin
            return nl[15:0];
        end
        return v;
    endfunction

    logic signed [15:0] clamped;
    logic        [31:0] prod;
    logic        [27:0] step;
    logic signed [16:0] diff;
    logic signed [29:0] diff_w;
    logic signed [29:0] step_p;
    logic signed [29:0] step_n;

    assign o_emg_v = (EMG_CLAMP_EN != 0) ? f_clamp(i_emg_v, i_lim) : i_emg_v;
    assign clamped = f_clamp(i_auto_v, i_lim);

    // Step in Q3.12 units: rate is 2^-16 per ms, so drop four bits.
    assign prod   = {16'd0, i_rate} * {16'd0, i_dt};
    assign step   = prod[31:4];
    assign diff   = {clamped[15], clamped} - {i_prev_v[15], i_prev_v};
    assign diff_w = {{13{diff[16]}}, diff};
    assign step_p = {2'b00, step};
    assign step_n = -step_p;

    always_comb begin
        if (i_rate == 16'd0) begin
            o_auto_v = clamped;
        end else if (diff_w > step_p) begin
            // Result lies between prev and target, so the low half is exact.
            o_auto_v = i_prev_v + $signed(step[15:0]);
        end else if (diff_w < step_n) begin
            o_auto_v = i_prev_v - $signed(step[15:0]);
        end else begin
            o_auto_v = clamped;
        end
    end

endmodule

`default_nettype wire

// ----- sv/dcsg_state.sv -----
// Command store of the safety gate: latched commands, ages and publish interval.
// Depends on dcsg_pkg.
`default_nettype none

module dcsg_state
    import dcsg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire t_cmd               i_cmd,
    input  wire logic signed [15:0] i_vx,
    input  wire logic signed [15:0] i_vy,
    input  wire logic signed [15:0] i_wz,
    input  wire logic               i_enable,
    input  wire logic               i_label,
    input  wire logic        [15:0] i_watchdog_ms,
    input  wire logic        [15:0] i_emg_timeout_ms,
    output logic signed      [15:0] o_auto_vx,
    output logic signed      [15:0] o_auto_vy,
    output logic signed      [15:0] o_auto_wz,
    output logic signed      [15:0] o_emg_vx,
    output logic signed      [15:0] o_emg_vy,
    output logic signed      [15:0] o_emg_wz,
    output t_status                 o_status
);

    logic signed [15:0] r_auto_vx, r_auto_vy, r_auto_wz;
    logic signed [15:0] r_emg_vx, r_emg_vy, r_emg_wz;
    logic        [1:0]  r_auto_flags, r_emg_flags;
    logic               r_emg_seen;
    logic        [16:0] r_auto_age, r_emg_age;
    logic        [15:0] r_ms_pub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_vx    <= '0;
            r_auto_vy    <= '0;
            r_auto_wz    <= '0;
            r_emg_vx     <= '0;
            r_emg_vy     <= '0;
            r_emg_wz     <= '0;
            r_auto_flags <= '0;
            r_emg_flags  <= '0;
            r_emg_seen   <= 1'b0;
            r_auto_age   <= '0;
            r_emg_age    <= '0;
            r_ms_pub     <= '0;
        end else if (i_fire) begin
            case (i_cmd)
                CMD_AUTO: begin
                    r_auto_vx    <= i_vx;
                    r_auto_vy    <= i_vy;
                    r_auto_wz    <= i_wz;
                    r_auto_flags <= {i_label, i_enable};
                    r_auto_age   <= '0;
                end
                CMD_EMG: begin
                    r_emg_vx    <= i_vx;
                    r_emg_vy    <= i_vy;
                    r_emg_wz    <= i_wz;
                    r_emg_flags <= {i_label, i_enable};
                    r_emg_seen  <= 1'b1;
                    r_emg_age   <= '0;
                end
                CMD_TICK: begin
                    // Saturate all counters.
                    if (r_auto_age != AGE_MAX) r_auto_age <= r_auto_age + 17'd1;
                    if (r_emg_age != AGE_MAX)  r_emg_age  <= r_emg_age + 17'd1;
                    if (r_ms_pub != PUB_MAX)   r_ms_pub   <= r_ms_pub + 16'd1;
                end
                CMD_PUBLISH: begin
                    r_ms_pub <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_auto_vx = r_auto_vx;
    assign o_auto_vy = r_auto_vy;
    assign o_auto_wz = r_auto_wz;
    assign o_emg_vx  = r_emg_vx;
    assign o_emg_vy  = r_emg_vy;
    assign o_emg_wz  = r_emg_wz;

    always_comb begin
        o_status.emg_fresh = r_emg_seen && (r_emg_age <= {1'b0, i_emg_timeout_ms});
        o_status.auto_live = (r_auto_age <= {1'b0, i_watchdog_ms});
        o_status.auto_en   = r_auto_flags[0];
        o_status.auto_lbl  = r_auto_flags[1];
        o_status.emg_en    = r_emg_flags[0];
        o_status.emg_lbl   = r_emg_flags[1];
        o_status.dt        = (r_ms_pub == 16'd0) ? 16'd1 : r_ms_pub;
    end

endmodule

`default_nettype wire

// ----- sv/drive_command_safety_gate.sv -----
// Top level of the three-axis drive command safety gate.
// Depends on dcsg_pkg, dcsg_state, dcsg_axis and drive_command_safety_gate_assert.svh.
//
// The gate takes one request per clock while tready is high: store an
// automatic command, store an emergency command, advance time by one
// millisecond, or publish. Every request is registered on acceptance and
// handled in a single pass from the input register: a publish result is
// loaded into the result register when its pass fires and is offered on the
// master side from there; the other requests give no result. Throughput is
// one request per cycle while tready is high, set by that one registered
// pass, which holds the clamp, the 16x16 slew multiply and its compare for
// each axis. The slave side drops tready only while a publish sits in the
// input register and the result register still holds an untaken result.
// Write configuration only while the gate is idle. On publish a fresh
// emergency command wins (clamped when EMG_CLAMP_EN is 1); otherwise a stale
// automatic command gives a zeroed watchdog stop, and a live one is clamped,
// slewed from the last published value and zeroed when disabled.
`default_nettype none

module drive_command_safety_gate
    import dcsg_pkg::*;
#(
    parameter int EMG_CLAMP_EN = 1
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [55:0] i_s_tdata,   // vx_in[15:0], vy_in[31:16], wz_in[47:32],
                                          // enable_in[48], has_label[49], zero[55:50]
    input  wire logic [1:0]  i_s_tuser,   // cmd[1:0]
    // Result stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [55:0] o_m_tdata,   // enable_out[0], vx_out[16:1], vy_out[32:17],
                                          // wz_out[48:33], zero[55:49]
    output logic      [2:0]  o_m_tuser,   // source_kind[2:0]
    // Configuration writes.
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata
);

    `include "drive_command_safety_gate_assert.svh"

    // Configuration registers.
    logic [15:0] r_watchdog_ms, r_emg_timeout_ms;
    logic [14:0] r_max_vx, r_max_vy, r_max_wz;
    logic [15:0] r_slew_vx, r_slew_vy, r_slew_wz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_watchdog_ms    <= RST_WATCHDOG;
            r_emg_timeout_ms <= RST_EMG_TIMEOUT;
            r_max_vx         <= RST_MAX_V;
            r_max_vy         <= RST_MAX_V;
            r_max_wz         <= RST_MAX_WZ;
            r_slew_vx        <= RST_SLEW_V;
            r_slew_vy        <= RST_SLEW_V;
            r_slew_wz        <= RST_SLEW_WZ;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_WATCHDOG:    r_watchdog_ms    <= i_cfg_wdata;
                REG_EMG_TIMEOUT: r_emg_timeout_ms <= i_cfg_wdata;
                REG_MAX_VX:      r_max_vx         <= i_cfg_wdata[14:0];
                REG_MAX_VY:      r_max_vy         <= i_cfg_wdata[14:0];
                REG_MAX_WZ:      r_max_wz         <= i_cfg_wdata[14:0];
                REG_SLEW_VX:     r_slew_vx        <= i_cfg_wdata;
                REG_SLEW_VY:     r_slew_vy        <= i_cfg_wdata;
                REG_SLEW_WZ:     r_slew_wz        <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input register: one request waiting for its pass.
    logic               r_in_valid;
    t_cmd               r_cmd;
    logic signed [15:0] r_vx, r_vy, r_wz;
    logic               r_enable, r_label;

    // Result register.
    logic               r_out_valid;
    logic               r_out_en;
    logic signed [15:0] r_out_vx, r_out_vy, r_out_wz;
    t_kind              r_out_kind;

    logic advance;
    logic fire;
    logic publish;

    // Hold only a publish that has nowhere to go.
    assign advance    = !(r_cmd == CMD_PUBLISH && r_out_valid && !i_m_tready);
    assign fire       = r_in_valid && advance;
    assign publish    = fire && (r_cmd == CMD_PUBLISH);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_cmd    <= t_cmd'(i_s_tuser);
            r_vx     <= i_s_tdata[15:0];
            r_vy     <= i_s_tdata[31:16];
            r_wz     <= i_s_tdata[47:32];
            r_enable <= i_s_tdata[48];
            r_label  <= i_s_tdata[49];
        end
    end

    // Command store.
    logic signed [15:0] auto_vx, auto_vy, auto_wz;
    logic signed [15:0] emg_vx, emg_vy, emg_wz;
    t_status            status;

    dcsg_state u_state (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_cmd            (r_cmd),
        .i_vx             (r_vx),
        .i_vy             (r_vy),
        .i_wz             (r_wz),
        .i_enable         (r_enable),
        .i_label          (r_label),
        .i_watchdog_ms    (r_watchdog_ms),
        .i_emg_timeout_ms (r_emg_timeout_ms),
        .o_auto_vx        (auto_vx),
        .o_auto_vy        (auto_vy),
        .o_auto_wz        (auto_wz),
        .o_emg_vx         (emg_vx),
        .o_emg_vy         (emg_vy),
        .o_emg_wz         (emg_wz),
        .o_status         (status)
    );

    // Last published velocities, the slew reference.
    logic signed [15:0] r_prev_vx, r_prev_vy, r_prev_wz;

    logic signed [15:0] emg_cx, emg_cy, emg_cz;
    logic signed [15:0] auto_sx, auto_sy, auto_sz;

    dcsg_axis #(.EMG_CLAMP_EN(EMG_CLAMP_EN)) u_axis_vx (
        .i_emg_v  (emg_vx),
        .i_auto_v (auto_vx),
        .i_prev_v (r_prev_vx),
        .i_lim    (r_max_vx),
        .i_rate   (r_slew_vx),
        .i_dt     (status.dt),
        .o_emg_v  (emg_cx),
        .o_auto_v (auto_sx)
    );

    dcsg_axis #(.EMG_CLAMP_EN(EMG_CLAMP_EN)) u_axis_vy (
        .i_emg_v  (emg_vy),
        .i_auto_v (auto_vy),
        .i_prev_v (r_prev_vy),
        .i_lim    (r_max_vy),
        .i_rate   (r_slew_vy),
        .i_dt     (status.dt),
        .o_emg_v  (emg_cy),
        .o_auto_v (auto_sy)
    );

    dcsg_axis #(.EMG_CLAMP_EN(EMG_CLAMP_EN)) u_axis_wz (
        .i_emg_v  (emg_wz),
        .i_auto_v (auto_wz),
        .i_prev_v (r_prev_wz),
        .i_lim    (r_max_wz),
        .i_rate   (r_slew_wz),
        .i_dt     (status.dt),
        .o_emg_v  (emg_cz),
        .o_auto_v (auto_sz)
    );

    // Pick the source of the published command.
    logic               n_en;
    logic signed [15:0] n_vx, n_vy, n_wz;
    t_kind              n_kind;

    always_comb begin
        n_en   = 1'b0;
        n_vx   = '0;
        n_vy   = '0;
        n_wz   = '0;
        n_kind = KIND_WDOG_STOP;
        if (status.emg_fresh) begin
            // Emergency passes through, also when it is disabled.
            n_en   = status.emg_en;
            n_vx   = emg_cx;
            n_vy   = emg_cy;
            n_wz   = emg_cz;
            n_kind = status.emg_lbl ? KIND_EMG_LABEL : KIND_EMG_DEFAULT;
        end else if (!status.auto_live) begin
            n_kind = KIND_WDOG_STOP;
        end else if (!status.auto_en) begin
            n_kind = KIND_AUTO_DISABLED;
        end else begin
            n_en   = 1'b1;
            n_vx   = auto_sx;
            n_vy   = auto_sy;
            n_wz   = auto_sz;
            n_kind = status.auto_lbl ? KIND_AUTO_LABEL : KIND_AUTO_DEFAULT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_vx <= '0;
            r_prev_vy <= '0;
            r_prev_wz <= '0;
        end else if (publish) begin
            r_prev_vx <= n_vx;
            r_prev_vy <= n_vy;
            r_prev_wz <= n_wz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (publish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (publish) begin
            r_out_en   <= n_en;
            r_out_vx   <= n_vx;
            r_out_vy   <= n_vy;
            r_out_wz   <= n_wz;
            r_out_kind <= n_kind;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_wz, r_out_vy, r_out_vx, r_out_en};
    assign o_m_tuser  = r_out_kind;

    // A stop result carries no motion.
    `DCSG_ASSERT_NOW(a_stop_zero,
        r_out_valid && (r_out_kind == KIND_WDOG_STOP || r_out_kind == KIND_AUTO_DISABLED),
        !r_out_en && r_out_vx == 16'sd0 && r_out_vy == 16'sd0 && r_out_wz == 16'sd0)
    // The slave side stalls only on a blocked publish.
    `DCSG_ASSERT_NOW(a_stall_cause, !o_s_tready,
        r_in_valid && r_cmd == CMD_PUBLISH && r_out_valid && !i_m_tready)
    // A publish always lands in the result register.
    `DCSG_ASSERT_NEXT(a_publish_lands, publish, r_out_valid)
    // The slew reference follows the published result.
    `DCSG_ASSERT_NEXT(a_prev_tracks, publish,
        r_prev_vx == r_out_vx && r_prev_vy == r_out_vy && r_prev_wz == r_out_wz)

endmodule

`default_nettype wire
